// File: design/nss_pkg.sv
`default_nettype none

package nss_pkg;

  // Coordinate and arithmetic widths
  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;        // Q - A, B - A
  localparam int SQ_W       = 2 * COORD_W;        // dx*dx, always below 2^32
  localparam int DOT_W      = 2 * COORD_W + 1;    // rx*dx, signed
  localparam int LEN_W      = 2 * COORD_W + 1;    // dx*dx + dy*dy
  localparam int NUM_W      = 2 * COORD_W + 2;    // rx*dx + ry*dy, signed
  localparam int Q_W        = 16;                 // quotient bits of t
  localparam int T_W        = Q_W + 1;            // t in Q1.16, up to 1.0
  localparam int DIV_STEPS  = Q_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int EPROD_W    = DIFF_W + T_W + 1;   // dx * t, signed
  localparam int MAG_W      = 2 * COORD_W;        // |ex| stays below 2^32
  localparam int ESQ_W      = 2 * MAG_W;
  localparam int DIST_W     = ESQ_W + 1 - 16;     // (ex^2 + ey^2) >> 16
  localparam int OUT_DIST_W = 52;
  localparam int IDX_W      = 16;
  localparam int LIM_W      = 17;
  localparam int LIM_SQ_W   = 2 * (LIM_W - 1);
  localparam int LIMIT_W    = LIM_SQ_W + 16;

  localparam logic [T_W-1:0] T_HALF = T_W'(32768);
  localparam logic [T_W-1:0] T_ZERO = '0;
  localparam logic [T_W-1:0] T_ONE  = T_W'(65536);

  // Stream widths
  localparam int IN_TDATA_W  = 4 * COORD_W;
  localparam int OUT_BITS    = 1 + IDX_W + T_W + OUT_DIST_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_X  = 2'd0,
    CFG_QUERY_Y  = 2'd1,
    CFG_MAX_DIST = 2'd2
  } cfg_idx_e;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified segment: offsets relative to A, plus the last flag
  typedef struct packed {
    logic signed [DIFF_W-1:0] rx;
    logic signed [DIFF_W-1:0] ry;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     last;
  } nss_seg_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] num;
    logic [LEN_W-1:0] den;
  } nss_div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
  } nss_div_rsp_t;

endpackage

`default_nettype wire

// File: design/nearest_segment_search_top.sv
// Nearest-segment search. Write the query point (index 0 and 1) and the distance limit
// (index 2, negative for none) while the block is idle, then stream segments A->B; the
// item with tlast set closes the query and yields one result with the nearest segment's
// stream index, its projection t in Q1.16 and its squared distance with 16 fractional
// bits, after which the search starts over. The back end works on one segment at a time:
// sum, error, magnitude, square and compare, waiting on the 16-step restoring divider
// in between unless t clamps to 0 or 1 or the segment has zero length. A two-entry queue
// lets the input side run ahead while the back end works or a result waits to be taken.
`default_nettype none

module nearest_segment_search_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [nss_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [nss_pkg::LIM_W-1:0]         cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // seg_ax, seg_ay, seg_bx, seg_by
  input  wire logic [nss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // last_seg
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // found, best_index, offset, best_dist_sq, zero pad
  output logic [nss_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  logic                                q_full, q_push, q_empty, q_pop;
  nss_pkg::nss_seg_t                   q_wdata, q_head;
  logic signed [nss_pkg::LIM_W-1:0]    max_dist;
  nss_pkg::nss_div_req_t               div_req;
  nss_pkg::nss_div_rsp_t               div_rsp;

  nss_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .max_dist_o (max_dist)
  );

  nss_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  nss_div u_div (
    .clk_i, .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  nss_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .max_dist_i (max_dist),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule

`default_nettype wire

// File: design/nss_front.sv
`default_nettype none

module nss_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [nss_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [nss_pkg::LIM_W-1:0]            cfg_wdata_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [nss_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  input  wire logic                                 s_axis_tlast,
  input  wire logic                                 q_full_i,
  output logic                                      q_push_o,
  output nss_pkg::nss_seg_t                         q_data_o,
  output logic signed [nss_pkg::LIM_W-1:0]          max_dist_o
);

  localparam int CW = nss_pkg::COORD_W;

  logic [CW-1:0]                   qx_q, qy_q;
  logic signed [nss_pkg::LIM_W-1:0] max_dist_q;
  logic [CW-1:0]                   ax, ay, bx, by;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q       <= '0;
      qy_q       <= '0;
      max_dist_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nss_pkg::CFG_QUERY_X:  qx_q       <= cfg_wdata_i[CW-1:0];
        nss_pkg::CFG_QUERY_Y:  qy_q       <= cfg_wdata_i[CW-1:0];
        nss_pkg::CFG_MAX_DIST: max_dist_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign ax = s_axis_tdata[CW-1:0];
  assign ay = s_axis_tdata[2*CW-1:CW];
  assign bx = s_axis_tdata[3*CW-1:2*CW];
  assign by = s_axis_tdata[4*CW-1:3*CW];

  // Accept whenever the queue has room
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  // Offsets relative to the segment start, exact in 17 bits
  assign q_data_o.rx   = $signed({qx_q[CW-1], qx_q}) - $signed({ax[CW-1], ax});
  assign q_data_o.ry   = $signed({qy_q[CW-1], qy_q}) - $signed({ay[CW-1], ay});
  assign q_data_o.dx   = $signed({bx[CW-1], bx}) - $signed({ax[CW-1], ax});
  assign q_data_o.dy   = $signed({by[CW-1], by}) - $signed({ay[CW-1], ay});
  assign q_data_o.last = s_axis_tlast;

  assign max_dist_o = max_dist_q;

endmodule

`default_nettype wire

// File: design/nss_queue.sv
`default_nettype none

module nss_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  nss_pkg::nss_seg_t  data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output nss_pkg::nss_seg_t  head_o
);

  nss_pkg::nss_seg_t               mem_q [nss_pkg::QDEPTH];
  logic [nss_pkg::QPTR_W-1:0]      wptr_q, rptr_q;
  logic [nss_pkg::QCNT_W-1:0]      cnt_q;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == nss_pkg::QCNT_W'(nss_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/nss_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle: quo = floor(num * 2^16 / den), num < den
module nss_div (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  nss_pkg::nss_div_req_t req_i,
  output nss_pkg::nss_div_rsp_t rsp_o
);

  localparam int LW = nss_pkg::LEN_W;

  logic                            busy_q, done_q;
  logic [nss_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [LW-1:0]                   rem_q, den_q;
  logic [nss_pkg::Q_W-1:0]         quo_q;
  logic [LW:0]                     shifted, diff;
  logic                            ge;

  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_q <= busy_q && !req_i.start && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= nss_pkg::DIV_CNT_W'(nss_pkg::DIV_STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath; remainder stays below den, so it fits LW bits
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[LW-1:0] : shifted[LW-1:0];
      quo_q <= {quo_q[nss_pkg::Q_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

// File: design/nss_back.sv
`default_nettype none

module nss_back (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 q_empty_i,
  input  nss_pkg::nss_seg_t                         q_head_i,
  output logic                                      q_pop_o,
  input  wire logic signed [nss_pkg::LIM_W-1:0]     max_dist_i,
  output nss_pkg::nss_div_req_t                     div_req_o,
  input  nss_pkg::nss_div_rsp_t                     div_rsp_i,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [nss_pkg::OUT_TDATA_W-1:0]           m_axis_tdata
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SUM  = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_ERR  = 7'b0001000,
    ST_MAG  = 7'b0010000,
    ST_SQ   = 7'b0100000,
    ST_CMP  = 7'b1000000
  } state_e;

  localparam int DW = nss_pkg::DIFF_W;

  state_e state_q, state_d;

  // Working registers
  logic signed [DW-1:0]                  rx_q, ry_q, dx_q, dy_q;
  logic                                  last_q;
  logic [nss_pkg::SQ_W-1:0]              pxx_q, pyy_q;
  logic signed [nss_pkg::DOT_W-1:0]      prx_q, pry_q;
  logic [nss_pkg::LIM_SQ_W-1:0]          lim2_q;
  logic [nss_pkg::T_W-1:0]               t_q, t_d;
  logic signed [nss_pkg::EPROD_W-1:0]    pxt_q, pyt_q;
  logic [nss_pkg::MAG_W-1:0]             mx_q, my_q;
  logic [nss_pkg::ESQ_W-1:0]             sx_q, sy_q;

  // Search state
  logic [nss_pkg::DIST_W-1:0]            best_dist_q;
  logic [nss_pkg::IDX_W-1:0]             best_pos_q, seg_cnt_q;
  logic [nss_pkg::T_W-1:0]               best_t_q;
  logic                                  have_best_q;
  logic                                  m_valid_q;
  logic [nss_pkg::OUT_TDATA_W-1:0]       m_data_q;

  // Products from the queue head
  logic signed [2*DW-1:0]                hxx, hyy, hrx, hry;
  assign hxx = q_head_i.dx * q_head_i.dx;
  assign hyy = q_head_i.dy * q_head_i.dy;
  assign hrx = q_head_i.rx * q_head_i.dx;
  assign hry = q_head_i.ry * q_head_i.dy;

  // Length and projection sums
  logic [nss_pkg::LEN_W-1:0]             len2;
  logic signed [nss_pkg::NUM_W-1:0]      num;
  logic                                  num_le0, num_ge_len;
  assign len2       = {1'b0, pxx_q} + {1'b0, pyy_q};
  assign num        = {prx_q[nss_pkg::DOT_W-1], prx_q} + {pry_q[nss_pkg::DOT_W-1], pry_q};
  assign num_le0    = num[nss_pkg::NUM_W-1] || (num == '0);
  assign num_ge_len = num[nss_pkg::LEN_W-1:0] >= len2;

  // Error terms
  logic signed [nss_pkg::EPROD_W-1:0]    pxt_c, pyt_c, ex, ey, ex_abs, ey_abs;
  assign pxt_c  = dx_q * $signed({1'b0, t_q});
  assign pyt_c  = dy_q * $signed({1'b0, t_q});
  assign ex     = $signed({{2{rx_q[DW-1]}}, rx_q, 16'b0}) - pxt_q;
  assign ey     = $signed({{2{ry_q[DW-1]}}, ry_q, 16'b0}) - pyt_q;
  assign ex_abs = ex[nss_pkg::EPROD_W-1] ? -ex : ex;
  assign ey_abs = ey[nss_pkg::EPROD_W-1] ? -ey : ey;

  // Distance and acceptance
  logic [nss_pkg::ESQ_W:0]               esum;
  logic [nss_pkg::DIST_W-1:0]            dist_sq;
  logic [nss_pkg::LIMIT_W-1:0]           limit;
  logic                                  accept, out_free, cmp_go;
  logic [nss_pkg::DIST_W-1:0]            new_dist;
  logic [nss_pkg::IDX_W-1:0]             new_pos;
  logic [nss_pkg::T_W-1:0]               new_t;
  logic                                  new_have;

  assign esum    = {1'b0, sx_q} + {1'b0, sy_q};
  assign dist_sq = esum[nss_pkg::ESQ_W:16];
  assign limit   = {lim2_q, 16'b0};

  always_comb begin
    if (have_best_q)            accept = dist_sq < best_dist_q;
    else if (max_dist_i[nss_pkg::LIM_W-1]) accept = 1'b1;
    else                        accept = dist_sq < {1'b0, limit};
  end

  assign new_dist = accept ? dist_sq   : best_dist_q;
  assign new_pos  = accept ? seg_cnt_q : best_pos_q;
  assign new_t    = accept ? t_q       : best_t_q;
  assign new_have = accept || have_best_q;

  assign out_free = !m_valid_q || m_axis_tready;
  assign cmp_go   = (state_q == ST_CMP) && (!last_q || out_free);

  // Sequencer
  always_comb begin
    state_d       = state_q;
    t_d           = t_q;
    q_pop_o       = 1'b0;
    div_req_o     = '0;
    div_req_o.num = num[nss_pkg::LEN_W-1:0];
    div_req_o.den = len2;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        state_d = ST_ERR;
        if (len2 == '0) begin
          t_d = nss_pkg::T_HALF;
        end else if (num_le0) begin
          t_d = nss_pkg::T_ZERO;
        end else if (num_ge_len) begin
          t_d = nss_pkg::T_ONE;
        end else begin
          div_req_o.start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          t_d     = {1'b0, div_rsp_i.quo};
          state_d = ST_ERR;
        end
      end
      ST_ERR:  state_d = ST_MAG;
      ST_MAG:  state_d = ST_SQ;
      ST_SQ:   state_d = ST_CMP;
      ST_CMP: begin
        if (cmp_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      best_dist_q <= '0;
      best_pos_q  <= '0;
      best_t_q    <= nss_pkg::T_HALF;
      have_best_q <= 1'b0;
      seg_cnt_q   <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new result may replace one taken at the same edge
      if (cmp_go && last_q) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cmp_go) begin
        if (last_q) begin
          best_dist_q <= '0;
          best_pos_q  <= '0;
          best_t_q    <= nss_pkg::T_HALF;
          have_best_q <= 1'b0;
          seg_cnt_q   <= '0;
        end else begin
          best_dist_q <= new_dist;
          best_pos_q  <= new_pos;
          best_t_q    <= new_t;
          have_best_q <= new_have;
          seg_cnt_q   <= seg_cnt_q + 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    if (q_pop_o) begin
      rx_q   <= q_head_i.rx;
      ry_q   <= q_head_i.ry;
      dx_q   <= q_head_i.dx;
      dy_q   <= q_head_i.dy;
      last_q <= q_head_i.last;
      pxx_q  <= hxx[nss_pkg::SQ_W-1:0];
      pyy_q  <= hyy[nss_pkg::SQ_W-1:0];
      prx_q  <= hrx[nss_pkg::DOT_W-1:0];
      pry_q  <= hry[nss_pkg::DOT_W-1:0];
    end
    if (state_q == ST_SUM) begin
      lim2_q <= max_dist_i[nss_pkg::LIM_W-2:0] * max_dist_i[nss_pkg::LIM_W-2:0];
    end
    if (state_q == ST_ERR) begin
      pxt_q <= pxt_c;
      pyt_q <= pyt_c;
    end
    if (state_q == ST_MAG) begin
      mx_q <= ex_abs[nss_pkg::MAG_W-1:0];
      my_q <= ey_abs[nss_pkg::MAG_W-1:0];
    end
    if (state_q == ST_SQ) begin
      sx_q <= mx_q * mx_q;
      sy_q <= my_q * my_q;
    end
    if (cmp_go && last_q) begin
      m_data_q <= nss_pkg::OUT_TDATA_W'({
        nss_pkg::OUT_DIST_W'(new_dist), new_t, new_pos, new_have});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// File: design/nss_checker.sv
`default_nettype none

module nss_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         cfg_we_i,
  input wire logic [1:0]   cfg_idx_i,
  input wire logic [16:0]  cfg_wdata_i,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [63:0]  s_axis_tdata,
  input wire logic         s_axis_tlast,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [87:0]  m_axis_tdata
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Nothing found gives the empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |->
      m_axis_tdata[16:1] == 16'd0 && m_axis_tdata[33:17] == 17'd32768 &&
      m_axis_tdata[85:34] == 52'd0)
    else $error("empty result carries data");

  // t never exceeds 1.0 and the distance keeps its top bits clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:17] <= 17'd65536 && m_axis_tdata[87:83] == 5'd0)
    else $error("result field out of range");

endmodule

bind nearest_segment_search_top nss_checker u_nss_checker (.*);

`default_nettype wire

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 holds no register; writes to it must leave the query alone
  localparam logic [nss_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1800;

  typedef logic signed [nss_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    logic   last;
  } segment_t;

  typedef struct packed {
    logic                           found;
    logic [nss_pkg::IDX_W-1:0]      index;
    logic [nss_pkg::T_W-1:0]        t;
    logic [nss_pkg::OUT_DIST_W-1:0] dist_sq;
  } answer_t;

  // DUT connections
  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [nss_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [nss_pkg::LIM_W-1:0]       cfg_wdata_i = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [nss_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [nss_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor copy of the registers and the search state
  coord_t                           query_x_cfg = '0;
  coord_t                           query_y_cfg = '0;
  logic signed [nss_pkg::LIM_W-1:0] max_dist_cfg = '1;
  logic [nss_pkg::OUT_DIST_W-1:0]   best_dist = '0;
  logic [nss_pkg::IDX_W-1:0]        best_pos = '0;
  logic [nss_pkg::T_W-1:0]          best_t = nss_pkg::T_HALF;
  logic [nss_pkg::IDX_W-1:0]        seg_count = '0;
  logic                             have_best = 1'b0;

  answer_t pending_answers[$];
  int      error_count = 0;
  int      segments_sent = 0;
  int      answers_seen = 0;
  int      send_gap_pct = 0;
  int      ready_stall_pct = 0;

  nearest_segment_search_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] %s", $realtime, msg);
    error_count++;
  endtask

  // Fold one segment into the running search; a marked last segment closes the query
  function automatic void fold_segment(input segment_t s);
    longint rx, ry, dx, dy, len2, num, t, ex, ey, lim;
    logic [63:0] ex_mag, ey_mag;
    logic [64:0] esq_sum;
    logic [nss_pkg::OUT_DIST_W-1:0] seg_dist;
    logic take;
    answer_t ans;
    rx = longint'(query_x_cfg) - longint'($signed(s.ax));
    ry = longint'(query_y_cfg) - longint'($signed(s.ay));
    dx = longint'($signed(s.bx)) - longint'($signed(s.ax));
    dy = longint'($signed(s.by)) - longint'($signed(s.ay));
    len2 = dx * dx + dy * dy;
    num = rx * dx + ry * dy;
    if (len2 == 0) begin
      t = 32768;
    end else if (num <= 0) begin
      t = 0;
    end else if (num >= len2) begin
      t = 65536;
    end else begin
      t = (num * 65536) / len2;
    end
    // error vector in Q.16, squared sum keeps its carry bit
    ex = rx * 65536 - dx * t;
    ey = ry * 65536 - dy * t;
    ex_mag = (ex < 0) ? -ex : ex;
    ey_mag = (ey < 0) ? -ey : ey;
    esq_sum = {1'b0, ex_mag * ex_mag} + {1'b0, ey_mag * ey_mag};
    seg_dist = nss_pkg::OUT_DIST_W'(esq_sum[64:16]);
    lim = longint'(max_dist_cfg);
    if (have_best) begin
      take = seg_dist < best_dist;
    end else if (lim < 0) begin
      take = 1'b1;
    end else begin
      take = longint'(seg_dist) < lim * lim * 65536;
    end
    if (take) begin
      best_dist = seg_dist;
      best_pos = seg_count;
      best_t = nss_pkg::T_W'(t);
      have_best = 1'b1;
    end
    seg_count++;
    if (s.last) begin
      ans.found = have_best;
      ans.index = have_best ? best_pos : '0;
      ans.t = have_best ? best_t : nss_pkg::T_HALF;
      ans.dist_sq = have_best ? best_dist : '0;
      pending_answers = {pending_answers, ans};
      best_dist = '0;
      best_pos = '0;
      best_t = nss_pkg::T_HALF;
      seg_count = '0;
      have_best = 1'b0;
    end
  endfunction

  function automatic segment_t make_segment(input int ax, input int ay, input int bx,
                                            input int by, input logic last);
    segment_t s;
    s.ax = coord_t'(ax);
    s.ay = coord_t'(ay);
    s.bx = coord_t'(bx);
    s.by = coord_t'(by);
    s.last = last;
    return s;
  endfunction

  // Send one item; valid stays high between back-to-back items
  task automatic send_segment(input segment_t s);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {s.by, s.bx, s.ay, s.ax};
    s_axis_tlast <= s.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fold_segment(s);
    segments_sent++;
  endtask

  // Drain all results, then let the back end settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [nss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nss_pkg::LIM_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      nss_pkg::CFG_QUERY_X: query_x_cfg = data[nss_pkg::COORD_W-1:0];
      nss_pkg::CFG_QUERY_Y: query_y_cfg = data[nss_pkg::COORD_W-1:0];
      nss_pkg::CFG_MAX_DIST: max_dist_cfg = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Result sink with random backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
  end

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got !== want) begin
      flag_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found = m_axis_tdata[0];
      got.index = m_axis_tdata[nss_pkg::IDX_W:1];
      got.t = m_axis_tdata[nss_pkg::IDX_W+nss_pkg::T_W:nss_pkg::IDX_W+1];
      got.dist_sq = m_axis_tdata[nss_pkg::IDX_W+nss_pkg::T_W+nss_pkg::OUT_DIST_W:
                                 nss_pkg::IDX_W+nss_pkg::T_W+1];
      answers_seen++;
      if (pending_answers.size() == 0) begin
        flag_error($sformatf("unexpected result: found=%0b index=%0d t=%0d dist=%0d",
                             got.found, got.index, got.t, got.dist_sq));
      end else begin
        want = pending_answers.pop_front();
        check_field("found", got.found, want.found);
        check_field("best_index", got.index, want.index);
        check_field("offset", got.t, want.t);
        check_field("best_dist_sq", got.dist_sq, want.dist_sq);
      end
    end
  end

  function automatic coord_t corner_coord();
    case ($urandom_range(3))
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return coord_t'(0);
      default: return coord_t'(-1);
    endcase
  endfunction

  // Mix of wide random, near-query, zero-length and corner segments
  function automatic segment_t random_segment(input logic last);
    segment_t s;
    int unsigned pick;
    pick = $urandom_range(9);
    s.ax = coord_t'($urandom);
    s.ay = coord_t'($urandom);
    s.bx = coord_t'($urandom);
    s.by = coord_t'($urandom);
    if (pick >= 4 && pick <= 8) begin
      s.ax = query_x_cfg + coord_t'($urandom_range(1000)) - coord_t'(500);
      s.ay = query_y_cfg + coord_t'($urandom_range(1000)) - coord_t'(500);
      s.bx = query_x_cfg + coord_t'($urandom_range(1000)) - coord_t'(500);
      s.by = query_y_cfg + coord_t'($urandom_range(1000)) - coord_t'(500);
    end else if (pick == 9) begin
      s.ax = corner_coord();
      s.ay = corner_coord();
      s.bx = corner_coord();
      s.by = corner_coord();
    end
    if (pick == 8) begin
      s.bx = s.ax;
      s.by = s.ay;
    end
    s.last = last;
    return s;
  endfunction

  task automatic randomize_config();
    int unsigned pick;
    if ($urandom_range(99) < 60) begin
      cfg_write(nss_pkg::CFG_QUERY_X,
                ($urandom_range(99) < 70) ? nss_pkg::LIM_W'($urandom)
                                          : nss_pkg::LIM_W'($urandom_range(400)));
    end
    if ($urandom_range(99) < 60) begin
      cfg_write(nss_pkg::CFG_QUERY_Y,
                ($urandom_range(99) < 70) ? nss_pkg::LIM_W'($urandom)
                                          : nss_pkg::LIM_W'($urandom_range(400)));
    end
    if ($urandom_range(99) < 60) begin
      pick = $urandom_range(9);
      if (pick < 3) begin
        cfg_write(nss_pkg::CFG_MAX_DIST, '1);
      end else if (pick < 7) begin
        cfg_write(nss_pkg::CFG_MAX_DIST, nss_pkg::LIM_W'($urandom_range(600)));
      end else begin
        cfg_write(nss_pkg::CFG_MAX_DIST, nss_pkg::LIM_W'($urandom_range(65535)));
      end
    end
  endtask

  // Clamping, zero length, divider path, ties and coordinate extremes
  task automatic test_directed_geometry();
    send_segment(make_segment(3, 4, 3, 4, 1'b1));
    send_segment(make_segment(10, 10, 20, 20, 1'b0));
    send_segment(make_segment(-20, -20, -10, -10, 1'b0));
    send_segment(make_segment(-7, 3, 11, 5, 1'b0));
    send_segment(make_segment(-7, 3, 11, 5, 1'b1));
    wait_idle();
    // upper bit of the write data is outside the query register
    cfg_write(nss_pkg::CFG_QUERY_X, 17'h18000);
    cfg_write(nss_pkg::CFG_QUERY_Y, 17'h08000);
    send_segment(make_segment(32767, 32767, -32768, 32767, 1'b0));
    send_segment(make_segment(-32768, -32768, 32767, 32767, 1'b0));
    send_segment(make_segment(32767, -32768, 32767, -32768, 1'b1));
    wait_idle();
    cfg_write(nss_pkg::CFG_QUERY_X, 17'h07FFF);
    cfg_write(nss_pkg::CFG_QUERY_Y, 17'h07FFF);
    send_segment(make_segment(-32768, -32768, -32768, 32767, 1'b0));
    send_segment(make_segment(-32768, 32767, 32767, -32768, 1'b1));
    wait_idle();
  endtask

  // Zero limit, strict bound, nothing found, widest limit
  task automatic test_distance_limit();
    cfg_write(nss_pkg::CFG_QUERY_X, '0);
    cfg_write(nss_pkg::CFG_QUERY_Y, '0);
    cfg_write(nss_pkg::CFG_MAX_DIST, '0);
    send_segment(make_segment(-5, 0, 5, 0, 1'b1));
    wait_idle();
    cfg_write(nss_pkg::CFG_MAX_DIST, 17'd10);
    send_segment(make_segment(20, 0, 20, 5, 1'b0));
    send_segment(make_segment(3, -9, 3, 9, 1'b1));
    wait_idle();
    cfg_write(nss_pkg::CFG_MAX_DIST, 17'd3);
    send_segment(make_segment(3, -1, 3, 1, 1'b1));
    wait_idle();
    cfg_write(nss_pkg::CFG_MAX_DIST, 17'd65535);
    send_segment(make_segment(32767, 32767, 32767, 32767, 1'b1));
    wait_idle();
    cfg_write(nss_pkg::CFG_MAX_DIST, '1);
  endtask

  task automatic test_unused_register();
    cfg_write(CFG_UNUSED, 17'h15A5A);
    send_segment(make_segment(1, 2, 3, 4, 1'b1));
    wait_idle();
  endtask

  // Random queries under three idling mixes, config changed now and then
  task automatic test_random_queries();
    int sent_in_phase;
    int len;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 21;
          ready_stall_pct = 74;
        end
        1: begin
          send_gap_pct = 74;
          ready_stall_pct = 21;
        end
        default: begin
          send_gap_pct = 0;
          ready_stall_pct = 0;
        end
      endcase
      sent_in_phase = 0;
      while (sent_in_phase < RANDOM_ITEMS / 3) begin
        if ($urandom_range(99) < 20) begin
          wait_idle();
          randomize_config();
        end
        len = ($urandom_range(99) < 85) ? $urandom_range(6, 1) : $urandom_range(40, 7);
        for (int k = 0; k < len; k++) begin
          send_segment(random_segment(k == len - 1));
        end
        sent_in_phase += len;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_pct = 21;
    ready_stall_pct = 74;
    test_directed_geometry();
    test_distance_limit();
    test_unused_register();
    test_random_queries();
    wait_idle();
    $display("Sent %0d segments and checked %0d query results.", segments_sent, answers_seen);
    $display("Covered clamping, zero length, limits, unused index and three backpressure mixes.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
